>>> rtl/hpf_pkg.sv
package hpf_pkg;

  typedef enum logic [2:0] {
    PH_INIT       = 3'd0,
    PH_PREP       = 3'd1,
    PH_SYNC       = 3'd2,
    PH_CONNECTING = 3'd3,
    PH_CONNECTED  = 3'd4,
    PH_WAITING    = 3'd5,
    PH_FAILED     = 3'd6
  } phase_t;

  localparam logic [2:0] CMD_TRY  = 3'd0;
  localparam logic [2:0] CMD_INFO = 3'd1;
  localparam logic [2:0] CMD_STUN = 3'd2;
  localparam logic [2:0] CMD_HB   = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_HB   = 2'd1;
  localparam logic [1:0] ACT_INFO = 2'd2;
  localparam logic [1:0] ACT_STUN = 2'd3;

  localparam logic [2:0] CFG_LOCAL_P2P_DIS = 3'd0;
  localparam logic [2:0] CFG_RETRY_MIN     = 3'd1;
  localparam logic [2:0] CFG_RETRY_MAX     = 3'd2;
  localparam logic [2:0] CFG_SETUP_TMO     = 3'd3;
  localparam logic [2:0] CFG_LINK_TMO      = 3'd4;

  localparam logic [15:0] RETRY_MIN_RST = 16'd30;
  localparam logic [15:0] RETRY_MAX_RST = 16'd3600;
  localparam logic [7:0]  SETUP_TMO_RST = 8'd10;
  localparam logic [7:0]  LINK_TMO_RST  = 8'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic        info_is_local;
    logic        heartbeat_ack;
  } hpf_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic        ack_out;
    logic        request_local;
    logic        accepted;
    logic [2:0]  phase;
    logic        connected;
    logic        last;
  } hpf_out_t;

  typedef struct packed {
    hpf_out_t res0;
    hpf_out_t res1;
    logic     two;
  } hpf_pair_t;

  typedef struct packed {
    logic        local_p2p_disabled;
    logic [15:0] retry_min_seconds;
    logic [15:0] retry_max_seconds;
    logic [7:0]  setup_timeout_seconds;
    logic [7:0]  link_timeout_seconds;
  } hpf_cfg_t;

  // Private, loopback and link-local ranges.
  function automatic logic ip_is_local(input logic [31:0] ip);
    logic hit;
    hit = ((ip & 32'hFF000000) == 32'h0A000000) ||
          ((ip & 32'hFFF00000) == 32'hAC100000) ||
          ((ip & 32'hFFFF0000) == 32'hC0A80000) ||
          ((ip & 32'hFF000000) == 32'h7F000000) ||
          ((ip & 32'hFFFF0000) == 32'hA9FE0000);
    return hit;
  endfunction

endpackage

>>> rtl/hpf_cfg_regs.sv
module hpf_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output hpf_pkg::hpf_cfg_t cfg
);

  hpf_pkg::hpf_cfg_t cfg_r;
  hpf_pkg::hpf_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        hpf_pkg::CFG_LOCAL_P2P_DIS: cfg_nxt.local_p2p_disabled = cfg_data[0];
        hpf_pkg::CFG_RETRY_MIN:     cfg_nxt.retry_min_seconds = cfg_data;
        hpf_pkg::CFG_RETRY_MAX:     cfg_nxt.retry_max_seconds = cfg_data;
        hpf_pkg::CFG_SETUP_TMO:     cfg_nxt.setup_timeout_seconds = cfg_data[7:0];
        hpf_pkg::CFG_LINK_TMO:      cfg_nxt.link_timeout_seconds = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_p2p_disabled    <= 1'b0;
      cfg_r.retry_min_seconds     <= hpf_pkg::RETRY_MIN_RST;
      cfg_r.retry_max_seconds     <= hpf_pkg::RETRY_MAX_RST;
      cfg_r.setup_timeout_seconds <= hpf_pkg::SETUP_TMO_RST;
      cfg_r.link_timeout_seconds  <= hpf_pkg::LINK_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/hpf_in_reg.sv
module hpf_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hpf_pkg::hpf_in_t in_data,
  output logic             item_vld,
  output hpf_pkg::hpf_in_t item,
  input  logic             take
);

  logic             vld_r;
  logic             vld_nxt;
  hpf_pkg::hpf_in_t item_r;

  assign in_ready = !vld_r || take;
  assign item_vld = vld_r;
  assign item = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

>>> rtl/hpf_core.sv
module hpf_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  hpf_pkg::hpf_in_t   item,
  input  hpf_pkg::hpf_cfg_t  cfg,
  output hpf_pkg::hpf_pair_t pair
);

  hpf_pkg::phase_t phase_r, phase_nxt, tgt;
  logic        wide_vld_r, wide_vld_nxt;
  logic        local_vld_r, local_vld_nxt;
  logic        real_vld_r, real_vld_nxt;
  logic [47:0] wide_addr_r, wide_addr_nxt;
  logic [47:0] local_addr_r, local_addr_nxt;
  logic [47:0] real_addr_r, real_addr_nxt;
  logic        ack_r, ack_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        upd;

  logic [15:0] idle_inc;
  logic        setup_act;
  logic        link_act;
  logic        waited_out;
  logic [47:0] addr;
  logic        hb_local;
  logic        real_local;
  logic        hb_phase;
  logic [16:0] retry_dbl;
  logic [15:0] retry_capped;

  assign idle_inc   = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign setup_act  = idle_inc < {8'd0, cfg.setup_timeout_seconds};
  assign link_act   = idle_inc < {8'd0, cfg.link_timeout_seconds};
  assign waited_out = idle_inc >= retry_r;
  assign addr       = {item.peer_ip, item.peer_port};
  assign hb_local   = hpf_pkg::ip_is_local(item.peer_ip);
  assign real_local = hpf_pkg::ip_is_local(real_addr_r[47:16]);
  assign hb_phase   = (phase_r == hpf_pkg::PH_PREP) || (phase_r == hpf_pkg::PH_SYNC) ||
                      (phase_r == hpf_pkg::PH_CONNECTING) ||
                      (phase_r == hpf_pkg::PH_CONNECTED);
  assign retry_dbl    = {retry_r, 1'b0};
  assign retry_capped = (retry_dbl < {1'b0, cfg.retry_max_seconds}) ? retry_dbl[15:0]
                                                                    : cfg.retry_max_seconds;

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    wide_vld_nxt   = wide_vld_r;
    local_vld_nxt  = local_vld_r;
    real_vld_nxt   = real_vld_r;
    wide_addr_nxt  = wide_addr_r;
    local_addr_nxt = local_addr_r;
    real_addr_nxt  = real_addr_r;
    ack_nxt        = ack_r;
    retry_nxt      = retry_r;
    idle_nxt       = idle_r;
    upd            = 1'b0;
    tgt            = phase_r;
    if (take) begin
      unique case (item.cmd)
        hpf_pkg::CMD_TRY: begin
          if (phase_r == hpf_pkg::PH_INIT) begin
            upd = 1'b1;
            tgt = hpf_pkg::PH_PREP;
          end
        end
        hpf_pkg::CMD_INFO: begin
          if (item.info_is_local) begin
            local_addr_nxt = addr;
            local_vld_nxt  = 1'b1;
          end else begin
            wide_addr_nxt = addr;
            wide_vld_nxt  = 1'b1;
            if (phase_r == hpf_pkg::PH_SYNC) begin
              upd = 1'b1;
              tgt = hpf_pkg::PH_CONNECTING;
            end else if (phase_r != hpf_pkg::PH_CONNECTED &&
                         phase_r != hpf_pkg::PH_CONNECTING) begin
              upd = 1'b1;
              tgt = hpf_pkg::PH_PREP;
            end
          end
        end
        hpf_pkg::CMD_STUN: begin
          if (phase_r == hpf_pkg::PH_PREP) begin
            upd = 1'b1;
            tgt = wide_vld_r ? hpf_pkg::PH_CONNECTING : hpf_pkg::PH_SYNC;
          end
        end
        hpf_pkg::CMD_HB: begin
          // A local-network heartbeat is dropped entirely when local P2P is off.
          if (hb_phase && (!hb_local || !cfg.local_p2p_disabled)) begin
            if (!hb_local) begin
              wide_addr_nxt = addr;
              wide_vld_nxt  = 1'b1;
            end else begin
              local_addr_nxt = addr;
              local_vld_nxt  = 1'b1;
            end
            // A local path, once known, is preferred over a wide one.
            if (!real_vld_r || hb_local || !real_local) begin
              real_addr_nxt = addr;
              real_vld_nxt  = 1'b1;
            end
            ack_nxt = 1'b1;
            if (item.heartbeat_ack) begin
              upd = 1'b1;
              tgt = hpf_pkg::PH_CONNECTED;
            end
          end
        end
        hpf_pkg::CMD_TICK: begin
          idle_nxt = idle_inc;
          unique case (phase_r)
            hpf_pkg::PH_PREP, hpf_pkg::PH_SYNC: begin
              if (!setup_act) begin
                upd = 1'b1;
                tgt = hpf_pkg::PH_FAILED;
              end
            end
            hpf_pkg::PH_CONNECTING: begin
              if (!setup_act) begin
                upd = 1'b1;
                tgt = hpf_pkg::PH_WAITING;
              end
            end
            hpf_pkg::PH_CONNECTED: begin
              if (!link_act) begin
                upd = 1'b1;
                tgt = hpf_pkg::PH_INIT;
              end
            end
            hpf_pkg::PH_WAITING: begin
              if (waited_out) begin
                upd = 1'b1;
                tgt = hpf_pkg::PH_INIT;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (upd) begin
      idle_nxt = 16'd0;
      if (tgt != phase_r) begin
        phase_nxt = tgt;
        if (tgt == hpf_pkg::PH_INIT || tgt == hpf_pkg::PH_WAITING ||
            tgt == hpf_pkg::PH_FAILED) begin
          wide_vld_nxt   = 1'b0;
          local_vld_nxt  = 1'b0;
          real_vld_nxt   = 1'b0;
          wide_addr_nxt  = 48'd0;
          local_addr_nxt = 48'd0;
          real_addr_nxt  = 48'd0;
          ack_nxt        = 1'b0;
        end
        if (phase_r == hpf_pkg::PH_WAITING && tgt == hpf_pkg::PH_INIT) begin
          retry_nxt = retry_capped;
        end else if (tgt == hpf_pkg::PH_INIT || tgt == hpf_pkg::PH_FAILED) begin
          retry_nxt = cfg.retry_min_seconds;
        end
      end
    end
  end

  // Result beats for the item.
  logic        c0_v, c1_v;
  logic [47:0] c0_addr, c1_addr;
  logic        accepted;

  always_comb begin
    pair    = '0;
    c0_v    = 1'b0;
    c1_v    = 1'b0;
    c0_addr = wide_addr_r;
    c1_addr = local_addr_r;
    unique case (item.cmd)
      hpf_pkg::CMD_INFO: begin
        if (!item.info_is_local && phase_r != hpf_pkg::PH_CONNECTED &&
            phase_r != hpf_pkg::PH_SYNC && phase_r != hpf_pkg::PH_CONNECTING) begin
          pair.res0.action        = hpf_pkg::ACT_INFO;
          pair.res0.request_local = 1'b1;
        end
      end
      hpf_pkg::CMD_STUN: begin
        if (phase_r == hpf_pkg::PH_PREP) begin
          pair.res0.action = hpf_pkg::ACT_INFO;
        end
      end
      hpf_pkg::CMD_TICK: begin
        unique case (phase_r)
          hpf_pkg::PH_PREP: begin
            if (setup_act) begin
              pair.res0.action = hpf_pkg::ACT_STUN;
            end
          end
          hpf_pkg::PH_SYNC: begin
            c1_v = setup_act && local_vld_r;
          end
          hpf_pkg::PH_CONNECTING: begin
            c0_v = setup_act && wide_vld_r;
            c1_v = setup_act && local_vld_r;
          end
          hpf_pkg::PH_CONNECTED: begin
            c0_v    = link_act && real_vld_r;
            c0_addr = real_addr_r;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (c0_v) begin
      pair.res0.action    = hpf_pkg::ACT_HB;
      pair.res0.dest_ip   = c0_addr[47:16];
      pair.res0.dest_port = c0_addr[15:0];
      pair.res0.ack_out   = ack_r;
      if (c1_v) begin
        pair.two            = 1'b1;
        pair.res1.action    = hpf_pkg::ACT_HB;
        pair.res1.dest_ip   = c1_addr[47:16];
        pair.res1.dest_port = c1_addr[15:0];
        pair.res1.ack_out   = ack_r;
      end
    end else if (c1_v) begin
      pair.res0.action    = hpf_pkg::ACT_HB;
      pair.res0.dest_ip   = c1_addr[47:16];
      pair.res0.dest_port = c1_addr[15:0];
      pair.res0.ack_out   = ack_r;
    end
    pair.res0.accepted  = accepted;
    pair.res0.phase     = phase_nxt;
    pair.res0.connected = phase_nxt == hpf_pkg::PH_CONNECTED;
    pair.res0.last      = !pair.two;
    pair.res1.accepted  = accepted;
    pair.res1.phase     = phase_nxt;
    pair.res1.connected = phase_nxt == hpf_pkg::PH_CONNECTED;
    pair.res1.last      = 1'b1;
  end

  assign accepted = (item.cmd == hpf_pkg::CMD_TRY) && (phase_r == hpf_pkg::PH_INIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hpf_pkg::PH_INIT;
      wide_vld_r   <= 1'b0;
      local_vld_r  <= 1'b0;
      real_vld_r   <= 1'b0;
      wide_addr_r  <= 48'd0;
      local_addr_r <= 48'd0;
      real_addr_r  <= 48'd0;
      ack_r        <= 1'b0;
      retry_r      <= hpf_pkg::RETRY_MIN_RST;
      idle_r       <= 16'd0;
    end else begin
      phase_r      <= phase_nxt;
      wide_vld_r   <= wide_vld_nxt;
      local_vld_r  <= local_vld_nxt;
      real_vld_r   <= real_vld_nxt;
      wide_addr_r  <= wide_addr_nxt;
      local_addr_r <= local_addr_nxt;
      real_addr_r  <= real_addr_nxt;
      ack_r        <= ack_nxt;
      retry_r      <= retry_nxt;
      idle_r       <= idle_nxt;
    end
  end

  a_idle_clr_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != $past(phase_r)) |-> (idle_r == 16'd0))
    else $error("idle counter not cleared on phase change");

  a_addr_clr_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r != $past(phase_r)) && (phase_r == hpf_pkg::PH_INIT ||
      phase_r == hpf_pkg::PH_WAITING || phase_r == hpf_pkg::PH_FAILED))
    |-> (!wide_vld_r && !local_vld_r && !real_vld_r && !ack_r))
    else $error("addresses kept on entering init, waiting or failed");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> ($stable(phase_r) && $stable(idle_r) && $stable(retry_r)))
    else $error("state changed without an item");

  a_two_only_hb: assert property (@(posedge clk) disable iff (!rst_n)
    (take && pair.two) |-> (pair.res0.action == hpf_pkg::ACT_HB &&
                            pair.res1.action == hpf_pkg::ACT_HB))
    else $error("second result that is not a heartbeat");

endmodule

>>> rtl/hpf_out_buf.sv
module hpf_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  hpf_pkg::hpf_pair_t pair,
  input  logic               item_vld,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output hpf_pkg::hpf_out_t  out_data
);

  logic [1:0]        cnt_r, cnt_nxt;
  hpf_pkg::hpf_out_t slot0_r, slot1_r;
  logic              can_load;
  logic              beat;

  assign beat      = out_valid && out_ready;
  // A new pair may land when the buffer is empty or empties in this cycle.
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign take      = item_vld && can_load;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = pair.two ? 2'd2 : 2'd1;
    end else if (beat) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0_r <= pair.res0;
      slot1_r <= pair.res1;
    end else if (beat) begin
      slot0_r <= slot1_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!slot0_r.last && slot1_r.last))
    else $error("last flag misplaced in a two-beat item");

endmodule

>>> rtl/udp_peer_hole_punch_fsm.sv
// Path: an item accepted on in_ waits in the input register until the core takes it;
// its results go to the result buffer. Throughput: one item per cycle with out_ready
// high for one-result items; a two-heartbeat item fills the two-entry result buffer.
// Reset: rst_n is synchronous and active low; it returns the phase to init, clears
// addresses, ack and idle count, sets retry to 30 s and loads register defaults.
module udp_peer_hole_punch_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hpf_pkg::hpf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hpf_pkg::hpf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  hpf_pkg::hpf_cfg_t  cfg;
  hpf_pkg::hpf_in_t   item;
  hpf_pkg::hpf_pair_t pair;
  logic               item_vld;
  logic               take;

  hpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpf_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .item_vld (item_vld),
    .item     (item),
    .take     (take)
  );

  hpf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .cfg   (cfg),
    .pair  (pair)
  );

  hpf_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .item_vld  (item_vld),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
